/* rtl/dqbe_pkg.sv */
// Shared types, constants and the quadrature decode function for the
// button and encoder event block. No dependencies.
`default_nettype none

package dqbe_pkg;

    // Number of samples in the debounce window.
    localparam int DEPTH = 8;
    localparam int WPOS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [WPOS_W-1:0] WPOS_LAST = WPOS_W'(DEPTH - 1);

    // Bit positions in a sample word; 1 means active.
    localparam int NUM_IN = 3;
    localparam int BIT_A = 0;
    localparam int BIT_B = 1;
    localparam int BIT_MUTE = 2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_GAP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENCODER_START = 2'd2;

    localparam logic [7:0] HOLD_THRESHOLD_RESET = 8'd50;
    localparam logic [7:0] REPEAT_GAP_RESET = 8'd10;
    localparam logic [1:0] ENCODER_START_RESET = 2'd3;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    // Debounced view of one scan tick.
    typedef struct packed {
        logic [NUM_IN-1:0] stable;
        logic [NUM_IN-1:0] changed;
        logic              window_end;
    } deb_t;

    typedef struct packed {
        logic [7:0] hold_threshold;
        logic [7:0] repeat_gap;
    } hold_cfg_t;

    typedef struct packed {
        logic mute;
        logic up;
        logic down;
    } req_t;

    // Index is the previous (A,B) pair in the upper bits, current in the lower.
    function automatic dir_t quad_decode(input logic [3:0] idx);
        dir_t dir;
        unique case (idx) inside
            4'd2, 4'd4, 4'd11, 4'd13: dir = DIR_UP;
            4'd1, 4'd7, 4'd8, 4'd14:  dir = DIR_DOWN;
            default:                  dir = DIR_NONE;
        endcase
        return dir;
    endfunction

endpackage

`default_nettype wire

/* rtl/debounce_quadrature_button_events_core.sv */
// Top level of the debounce and button event block: input register, debounce
// ring, event decoder and output register. Depends on dqbe_pkg, dqbe_filter
// and dqbe_decoder.
// A request in the input register moves to the output register once that is free
// or not stalled. Throughput: one request per cycle; the input register and the
// output register each hold one request, so the input stalls only when both are
// full and the output is stalled.
// Reset clears the debounce ring, counters and valid flags and loads the
// register defaults; no clearing pass is needed.
`default_nettype none

module debounce_quadrature_button_events_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [dqbe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dqbe_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              a_level,
    input  wire logic                              b_level,
    input  wire logic                              mute_level,
    input  wire logic                              mode_level,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   mute_request,
    output logic                                   up_request,
    output logic                                   down_request
);

    dqbe_pkg::hold_cfg_t hold_cfg_reg;
    logic                enc_load;

    logic                          s1_valid_reg;
    logic [dqbe_pkg::NUM_IN-1:0]   s1_sample_reg;
    logic                          s1_mode_reg;
    logic                          out_valid_reg;
    dqbe_pkg::req_t                out_req_reg;

    logic                          s2_adv;
    logic                          step;
    logic                          load;
    logic [dqbe_pkg::NUM_IN-1:0]   sample_in;
    dqbe_pkg::deb_t                deb;
    dqbe_pkg::req_t                req;

    assign enc_load = cfg_we && (cfg_index == dqbe_pkg::CFG_ENCODER_START);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cfg_reg.hold_threshold <= dqbe_pkg::HOLD_THRESHOLD_RESET;
            hold_cfg_reg.repeat_gap <= dqbe_pkg::REPEAT_GAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dqbe_pkg::CFG_HOLD_THRESHOLD: hold_cfg_reg.hold_threshold <= cfg_data;
                dqbe_pkg::CFG_REPEAT_GAP:     hold_cfg_reg.repeat_gap <= cfg_data;
                // The start state goes straight into the decoder's history.
                dqbe_pkg::CFG_ENCODER_START:  ;
                default:                      ;
            endcase
        end
    end

    // Inputs are active low; the ring works on active-high samples.
    assign sample_in = ~{mute_level, b_level, a_level};

    assign s2_adv = !out_valid_reg || !out_stall;
    assign step = s1_valid_reg && s2_adv;
    assign in_stall = s1_valid_reg && !s2_adv;
    assign load = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                s1_valid_reg <= 1'b1;
            else if (step)
                s1_valid_reg <= 1'b0;
            if (step)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_sample_reg <= sample_in;
            s1_mode_reg <= mode_level;
        end
        if (step)
            out_req_reg <= req;
    end

    dqbe_filter u_filter (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .sample (s1_sample_reg),
        .deb    (deb)
    );

    dqbe_decoder u_decoder (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .button_mode (s1_mode_reg),
        .deb         (deb),
        .hold_cfg    (hold_cfg_reg),
        .enc_load    (enc_load),
        .enc_start   (cfg_data[1:0]),
        .req         (req)
    );

    assign out_valid = out_valid_reg;
    assign mute_request = out_req_reg.mute;
    assign up_request = out_req_reg.up;
    assign down_request = out_req_reg.down;

    // The input side stalls only when both stages hold a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");

    // A request moved out of the input register always lands in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("result lost after a step");

    // A stalled result is neither dropped nor altered.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(out_req_reg)))
        else $error("stalled result changed");

    // A debounced input can only be active if the newest sample is active.
    assert property (@(posedge clk) disable iff (!rst_n)
        step |-> ((deb.stable & ~s1_sample_reg) == '0))
        else $error("debounced state disagrees with newest sample");

endmodule

`default_nettype wire

/* rtl/dqbe_filter.sv */
// Debounce ring: keeps the last DEPTH samples and reports their AND.
// Depends on dqbe_pkg.
`default_nettype none

module dqbe_filter (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       step,
    input  wire logic [dqbe_pkg::NUM_IN-1:0] sample,
    output dqbe_pkg::deb_t                  deb
);

    logic [dqbe_pkg::NUM_IN-1:0] hist_reg [dqbe_pkg::DEPTH];
    logic [dqbe_pkg::WPOS_W-1:0] wpos_reg;
    logic [dqbe_pkg::WPOS_W-1:0] wpos_next;
    logic [dqbe_pkg::NUM_IN-1:0] stable_reg;
    logic [dqbe_pkg::NUM_IN-1:0] acc;

    // The entry at the write position is replaced by the new sample.
    always_comb
    begin
        acc = '1;
        for (int i = 0; i < dqbe_pkg::DEPTH; i++)
        begin
            if (dqbe_pkg::WPOS_W'(i) == wpos_reg)
                acc = acc & sample;
            else
                acc = acc & hist_reg[i];
        end
    end

    assign wpos_next = (wpos_reg == dqbe_pkg::WPOS_LAST) ? '0 : wpos_reg + 1'b1;

    always_comb
    begin
        deb.stable = acc;
        deb.changed = acc ^ stable_reg;
        deb.window_end = (wpos_reg == dqbe_pkg::WPOS_LAST);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dqbe_pkg::DEPTH; i++)
                hist_reg[i] <= '0;
            wpos_reg <= '0;
            stable_reg <= '0;
        end
        else if (step)
        begin
            hist_reg[wpos_reg] <= sample;
            wpos_reg <= wpos_next;
            stable_reg <= acc;
        end
    end

endmodule

`default_nettype wire

/* rtl/dqbe_decoder.sv */
// Event logic: quadrature decode, button edges and hold auto-repeat.
// Depends on dqbe_pkg.
`default_nettype none

module dqbe_decoder (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic                button_mode,
    input  wire dqbe_pkg::deb_t      deb,
    input  wire dqbe_pkg::hold_cfg_t hold_cfg,
    input  wire logic                enc_load,
    input  wire logic [1:0]          enc_start,
    output dqbe_pkg::req_t           req
);

    logic [3:0] enc_hist_reg;
    logic [3:0] enc_hist_next;
    logic [7:0] hold_up_reg;
    logic [7:0] hold_up_next;
    logic [7:0] hold_down_reg;
    logic [7:0] hold_down_next;
    logic [7:0] reload;
    logic       any_change;
    logic       edge_a;
    logic       edge_b;
    dqbe_pkg::dir_t dir;

    assign any_change = |deb.changed;
    assign edge_a = deb.changed[dqbe_pkg::BIT_A] && !deb.changed[dqbe_pkg::BIT_B];
    assign edge_b = deb.changed[dqbe_pkg::BIT_B] && !deb.changed[dqbe_pkg::BIT_A];
    assign reload = hold_cfg.hold_threshold - hold_cfg.repeat_gap;

    always_comb
    begin
        enc_hist_next = enc_hist_reg;
        if (any_change && !button_mode)
            enc_hist_next = {enc_hist_reg[1:0], deb.stable[dqbe_pkg::BIT_A],
                             deb.stable[dqbe_pkg::BIT_B]};
        dir = dqbe_pkg::quad_decode(enc_hist_next);

        req.mute = deb.changed[dqbe_pkg::BIT_MUTE] && deb.stable[dqbe_pkg::BIT_MUTE];
        req.up = 1'b0;
        req.down = 1'b0;

        hold_up_next = hold_up_reg;
        hold_down_next = hold_down_reg;
        if (deb.window_end && deb.stable[dqbe_pkg::BIT_A])
            hold_up_next = hold_up_reg + 8'd1;
        if (deb.window_end && deb.stable[dqbe_pkg::BIT_B])
            hold_down_next = hold_down_reg + 8'd1;

        if (!button_mode)
        begin
            if (any_change)
            begin
                req.up = (dir == dqbe_pkg::DIR_UP);
                req.down = (dir == dqbe_pkg::DIR_DOWN);
            end
        end
        else
        begin
            // A press or release edge clears its counter, then the repeat check runs on it.
            if (edge_a)
            begin
                req.up = deb.stable[dqbe_pkg::BIT_A];
                hold_up_next = '0;
            end
            if (edge_b)
            begin
                req.down = deb.stable[dqbe_pkg::BIT_B];
                hold_down_next = '0;
            end
            if (hold_up_next == hold_cfg.hold_threshold)
            begin
                req.up = 1'b1;
                hold_up_next = reload;
            end
            if (hold_down_next == hold_cfg.hold_threshold)
            begin
                req.down = 1'b1;
                hold_down_next = reload;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_hist_reg <= {2'b00, dqbe_pkg::ENCODER_START_RESET};
            hold_up_reg <= '0;
            hold_down_reg <= '0;
        end
        else if (enc_load)
        begin
            enc_hist_reg <= {2'b00, enc_start};
        end
        else if (step)
        begin
            enc_hist_reg <= enc_hist_next;
            hold_up_reg <= hold_up_next;
            hold_down_reg <= hold_down_next;
        end
    end

endmodule

`default_nettype wire

/* sim/tb_debounce_quadrature_button_events_core.sv */
// Self-checking bench for debounce_quadrature_button_events_core: scripted and
// random scan ticks, with random idle on the input and stall on the output, checked
// against a request tracker. Depends on dqbe_pkg and the core RTL.
module tb_debounce_quadrature_button_events_core;
    timeunit 1ns;
    timeprecision 1ps;

    // One scan tick as driven onto the ports.
    typedef struct packed {
        logic mode;
        logic mute;
        logic b;
        logic a;
    } scan_t;

    localparam int PHASE_SCANS = 155;
    localparam int NUM_SETTINGS = 6;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int NUM_PRESETS = 7;

    // Register settings applied one per phase after the reset defaults.
    localparam logic [7:0] SET_THRESHOLD [NUM_SETTINGS] = '{8'd3, 8'd0, 8'd255, 8'd0, 8'd2, 8'd1};
    localparam logic [7:0] SET_GAP [NUM_SETTINGS] = '{8'd1, 8'd1, 8'd255, 8'd0, 8'd200, 8'd0};
    localparam logic [7:0] SET_START [NUM_SETTINGS] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd3, 8'd0};

    // Scripted opening: levels {mode, mute, b, a} and how many ticks each is held.
    localparam logic [3:0] PRESET_LEVELS [NUM_PRESETS] =
        '{4'b0000, 4'b0111, 4'b1110, 4'b1000, 4'b1111, 4'b0101, 4'b1010};
    localparam int PRESET_TICKS [NUM_PRESETS] = '{8, 1, 8, 1, 2, 2, 1};

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [dqbe_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [dqbe_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic                            a_level = 1'b1;
    logic                            b_level = 1'b1;
    logic                            mute_level = 1'b1;
    logic                            mode_level = 1'b0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic                            mute_request;
    logic                            up_request;
    logic                            down_request;

    bit quiet = 1'b0;
    bit hold_off_pending = 1'b0;
    int stall_left = 0;

    class button_request_tracker;
        logic [dqbe_pkg::NUM_IN-1:0] ring [dqbe_pkg::DEPTH];
        int unsigned                 ring_pos;
        logic [dqbe_pkg::NUM_IN-1:0] debounced;
        logic [3:0]                  wheel_trail;
        logic [7:0]                  up_hold;
        logic [7:0]                  down_hold;
        logic [7:0]                  threshold;
        logic [7:0]                  gap;
        dqbe_pkg::req_t              expected_requests [$];
        int                          errors;
        int                          scans_seen;
        int                          ups_seen;
        int                          downs_seen;
        int                          mutes_seen;

        function new();
            foreach (ring[i])
                ring[i] = '0;
            ring_pos = 0;
            debounced = '0;
            threshold = dqbe_pkg::HOLD_THRESHOLD_RESET;
            gap = dqbe_pkg::REPEAT_GAP_RESET;
            wheel_trail = {2'b00, dqbe_pkg::ENCODER_START_RESET};
            up_hold = '0;
            down_hold = '0;
            errors = 0;
            scans_seen = 0;
            ups_seen = 0;
            downs_seen = 0;
            mutes_seen = 0;
        endfunction

        function void write_register(logic [dqbe_pkg::CFG_IDX_W-1:0] idx, logic [7:0] data);
            case (idx)
                dqbe_pkg::CFG_HOLD_THRESHOLD: threshold = data;
                dqbe_pkg::CFG_REPEAT_GAP:     gap = data;
                dqbe_pkg::CFG_ENCODER_START:  wheel_trail = {2'b00, data[1:0]};
                default: ;
            endcase
        endfunction

        // Quadrature direction from the position change along the Gray sequence.
        function dqbe_pkg::dir_t wheel_step(logic [1:0] prev_ab, logic [1:0] cur_ab);
            logic [1:0] prev_pos;
            logic [1:0] cur_pos;
            logic [1:0] delta;
            prev_pos = {prev_ab[1], prev_ab[1] ^ prev_ab[0]};
            cur_pos = {cur_ab[1], cur_ab[1] ^ cur_ab[0]};
            delta = cur_pos - prev_pos;
            if (delta == 2'd3)
                return dqbe_pkg::DIR_UP;
            if (delta == 2'd1)
                return dqbe_pkg::DIR_DOWN;
            return dqbe_pkg::DIR_NONE;
        endfunction

        function void note_scan(logic a, logic b, logic mute, logic mode);
            logic [dqbe_pkg::NUM_IN-1:0] all_held;
            logic [dqbe_pkg::NUM_IN-1:0] delta;
            dqbe_pkg::dir_t              dir;
            dqbe_pkg::req_t              req;
            ring[ring_pos] = ~{mute, b, a};
            ring_pos++;
            all_held = '1;
            foreach (ring[i])
                all_held &= ring[i];
            delta = all_held ^ debounced;
            debounced = all_held;
            req = '0;

            if (ring_pos == dqbe_pkg::DEPTH) begin
                ring_pos = 0;
                if (all_held[dqbe_pkg::BIT_A])
                    up_hold++;
                if (all_held[dqbe_pkg::BIT_B])
                    down_hold++;
            end

            if (delta != '0) begin
                if (delta[dqbe_pkg::BIT_MUTE] && all_held[dqbe_pkg::BIT_MUTE])
                    req.mute = 1'b1;
                if (!mode) begin
                    wheel_trail = {wheel_trail[1:0], all_held[dqbe_pkg::BIT_A],
                                   all_held[dqbe_pkg::BIT_B]};
                    dir = wheel_step(wheel_trail[3:2], wheel_trail[1:0]);
                    req.up = (dir == dqbe_pkg::DIR_UP);
                    req.down = (dir == dqbe_pkg::DIR_DOWN);
                end else begin
                    // A simultaneous change of both buttons is treated as noise.
                    if (delta[dqbe_pkg::BIT_A] && !delta[dqbe_pkg::BIT_B]) begin
                        if (all_held[dqbe_pkg::BIT_A])
                            req.up = 1'b1;
                        up_hold = '0;
                    end
                    if (delta[dqbe_pkg::BIT_B] && !delta[dqbe_pkg::BIT_A]) begin
                        if (all_held[dqbe_pkg::BIT_B])
                            req.down = 1'b1;
                        down_hold = '0;
                    end
                end
            end

            if (mode) begin
                if (up_hold == threshold) begin
                    req.up = 1'b1;
                    up_hold = threshold - gap;
                end
                if (down_hold == threshold) begin
                    req.down = 1'b1;
                    down_hold = threshold - gap;
                end
            end
            expected_requests.push_back(req);
            scans_seen++;
        endfunction

        function void compare_field(string label, logic want, logic got);
            if (got !== want) begin
                $display("%0t: %s request expected %0b, got %0b", $time, label, want, got);
                errors++;
            end
        endfunction

        function void check_requests(logic mute, logic up, logic down);
            dqbe_pkg::req_t want;
            if (expected_requests.size() == 0) begin
                $display("%0t: result with nothing outstanding, expected none, %s %0b %0b %0b",
                         $time, "got mute/up/down", mute, up, down);
                errors++;
                return;
            end
            want = expected_requests.pop_front();
            compare_field("mute", want.mute, mute);
            compare_field("up", want.up, up);
            compare_field("down", want.down, down);
            mutes_seen += (mute === 1'b1);
            ups_seen += (up === 1'b1);
            downs_seen += (down === 1'b1);
        endfunction
    endclass

    button_request_tracker tracker;

    debounce_quadrature_button_events_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .a_level      (a_level),
        .b_level      (b_level),
        .mute_level   (mute_level),
        .mode_level   (mode_level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mute_request (mute_request),
        .up_request   (up_request),
        .down_request (down_request)
    );

    always #2 clk = ~clk;

    task automatic send_scan(input scan_t lv);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        a_level <= lv.a;
        b_level <= lv.b;
        mute_level <= lv.mute;
        mode_level <= lv.mode;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_scan(lv.a, lv.b, lv.mute, lv.mode);
    endtask

    task automatic drain(input int extra_cycles);
        in_valid <= 1'b0;
        while (tracker.expected_requests.size() != 0)
            @(posedge clk);
        repeat (extra_cycles) @(posedge clk);
    endtask

    task automatic write_register(input logic [dqbe_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [7:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        tracker.write_register(idx, data);
    endtask

    // Mostly clean held levels: Gray steps of the wheel in encoder mode,
    // single button presses in button mode, with bounce and noise mixed in.
    task automatic run_random(input int quota);
        int         sent;
        int         span;
        int         pick;
        logic [1:0] wheel;
        scan_t      lv;
        sent = 0;
        wheel = 2'($urandom_range(0, 3));
        lv = {1'($urandom_range(0, 1)), 3'b111};
        while (sent < quota) begin
            if ($urandom_range(0, 9) == 0) begin
                span = $urandom_range(1, 6);
                repeat (span) send_scan(scan_t'(4'($urandom_range(0, 15))));
            end else begin
                if ($urandom_range(0, 4) == 0)
                    lv.mode = ~lv.mode;
                if (!lv.mode) begin
                    wheel = $urandom_range(0, 1) ? wheel + 2'd1 : wheel - 2'd1;
                    lv.a = ~wheel[1];
                    lv.b = ~(wheel[1] ^ wheel[0]);
                end else begin
                    pick = $urandom_range(0, 9);
                    if (pick < 4)
                        lv.a = ~lv.a;
                    else if (pick < 8)
                        lv.b = ~lv.b;
                    else begin
                        lv.a = ~lv.a;
                        lv.b = ~lv.b;
                    end
                end
                if ($urandom_range(0, 3) == 0)
                    lv.mute = ~lv.mute;
                pick = $urandom_range(0, 19);
                if (pick < 5)
                    span = $urandom_range(1, 7);
                else if (pick == 19)
                    span = $urandom_range(40, 120);
                else
                    span = $urandom_range(8, 30);
                repeat (span) send_scan(lv);
            end
            sent += span;
        end
    endtask

    // Result side: random stall bursts plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge clk);
            if (out_valid === 1'b1 && !out_stall)
                tracker.check_requests(mute_request, up_request, down_request);
            if (stall_left == 0) begin
                if (hold_off_pending) begin
                    hold_off_pending = 1'b0;
                    stall_left = HOLD_OFF_CYCLES;
                end else if (!quiet && $urandom_range(0, 5) == 0) begin
                    stall_left = $urandom_range(1, 9);
                end
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        int preset_scans;
        preset_scans = 0;
        tracker = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < NUM_PRESETS; p++) begin
            repeat (PRESET_TICKS[p]) send_scan(scan_t'(PRESET_LEVELS[p]));
            preset_scans += PRESET_TICKS[p];
        end
        run_random(PHASE_SCANS - preset_scans);

        for (int s = 0; s < NUM_SETTINGS; s++) begin
            drain(4);
            write_register(dqbe_pkg::CFG_HOLD_THRESHOLD, SET_THRESHOLD[s]);
            write_register(dqbe_pkg::CFG_REPEAT_GAP, SET_GAP[s]);
            write_register(dqbe_pkg::CFG_ENCODER_START, SET_START[s]);
            cfg_we <= 1'b0;
            if (s == 1)
                hold_off_pending = 1'b1;
            if (s == NUM_SETTINGS - 1)
                quiet = 1'b1;
            run_random(PHASE_SCANS);
        end

        drain(8);
        $display("Ran %0d scan ticks under %0d register settings;",
                 tracker.scans_seen, NUM_SETTINGS + 1);
        $display("results held %0d up, %0d down and %0d mute requests.",
                 tracker.ups_seen, tracker.downs_seen, tracker.mutes_seen);
        if (tracker.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d results still outstanding.", tracker.expected_requests.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
